// ===== rtl/ksi_pkg.sv =====
package ksi_pkg;

    localparam int TIME_W   = 63;
    localparam int CFG_W    = 63;
    localparam int CFG_IW   = 2;
    localparam int ACT_W    = 2;
    localparam int EIDX_W   = 12;
    localparam int FCOUNT_W = 13;
    localparam int IVL_W    = 24;
    localparam int MARGIN_W = IVL_W + 4;

    // margin is sixteen frame intervals
    localparam int MARGIN_SHIFT = 4;
    localparam int SCAN_BACK    = 32;
    localparam int SCAN_LEN     = 65;
    localparam int MIN_STEP     = 16;
    localparam int NK_BACK      = 16;
    localparam int SCAN_CNT_W   = 7;

    localparam logic [ACT_W-1:0] ACT_LOAD      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_AT_BEFORE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_NEXT_KEY  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_PREV_KEY  = 2'd3;

    localparam logic [CFG_IW-1:0] REG_FRAME_COUNT    = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FIRST_TIME     = 2'd1;
    localparam logic [CFG_IW-1:0] REG_FRAME_INTERVAL = 2'd2;

    localparam logic [IVL_W-1:0] FRAME_INTERVAL_RESET = 24'd40000;

    typedef struct packed {
        logic                valid;
        logic                key;
        logic [TIME_W-1:0]   pts;
    } entry_t;

endpackage

// ===== rtl/keyframe_seek_index.sv =====
// Channel   Handshake               Payload
// --------  ----------------------  --------------------------------------------------
// input     start && !busy          action, entry_index, entry_time, entry_valid,
//                                   entry_key, query_time
// result    done (one cycle)        found, frame_index, found_time
// config    cfg_write               cfg_index, cfg_data
//
// A load is written to the frame memory on acceptance and gives no result. A query
// reads entries through the memory's single read port, each in a read state and a
// check state: the bisection walk, a scan of up to 65 entries and, for the key
// actions, a keyframe walk. For a query, busy is high from the cycle after acceptance
// until the cycle in which done rises. Reset clears control, frame count and first
// time and presets the frame interval; the frame memory is undefined until loaded.
// The receiver cannot stall: done is high for exactly one cycle per query.
module keyframe_seek_index #(
    parameter int MAX_FRAMES = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ksi_pkg::ACT_W-1:0]          action,
    input  logic [ksi_pkg::EIDX_W-1:0]         entry_index,
    input  logic [ksi_pkg::TIME_W-1:0]         entry_time,
    input  logic                               entry_valid,
    input  logic                               entry_key,
    input  logic [ksi_pkg::TIME_W-1:0]         query_time,
    output logic                               done,
    output logic                               found,
    output logic [ksi_pkg::EIDX_W-1:0]         frame_index,
    output logic [ksi_pkg::TIME_W-1:0]         found_time,
    input  logic                               cfg_write,
    input  logic [ksi_pkg::CFG_IW-1:0]         cfg_index,
    input  logic [ksi_pkg::CFG_W-1:0]          cfg_data
);
    import ksi_pkg::*;

    localparam int IW = $clog2(MAX_FRAMES);
    localparam int NW = (IW + 2 > FCOUNT_W) ? IW + 2 : FCOUNT_W;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_FRAMES);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_BK_RD, S_BK_CHK, S_FW_RD, S_FW_CHK, S_PIVOT,
        S_SCAN_RD, S_SCAN_CHK, S_LOC_DONE, S_NK_RD, S_NK_CHK, S_PK_RD, S_PK_CHK
    } state_t;

    state_t                 state_reg;
    logic [FCOUNT_W-1:0]    frame_count_reg;
    logic [TIME_W-1:0]      first_time_reg;
    logic [IVL_W-1:0]       interval_reg;

    logic [ACT_W-1:0]       act_reg;
    logic [TIME_W-1:0]      ref_reg;
    logic [TIME_W-1:0]      lo_reg;
    logic [TIME_W:0]        hi_reg;
    logic [TIME_W-1:0]      pts_reg;
    logic [TIME_W-1:0]      last_reg;
    logic [NW-1:0]          p_reg;
    logic [NW-1:0]          cur_reg;
    logic [NW-1:0]          step_reg;
    logic [NW-1:0]          minf_reg;
    logic [NW-1:0]          cand_reg;
    logic                   have_cand_reg;
    logic [SCAN_CNT_W-1:0]  k_reg;
    logic                   loc_found_reg;
    logic [NW-1:0]          loc_frame_reg;

    logic                   done_reg;
    logic                   found_reg;
    logic [EIDX_W-1:0]      frame_index_reg;
    logic [TIME_W-1:0]      found_time_reg;

    entry_t                 mem [MAX_FRAMES];
    entry_t                 rd_word_reg;

    logic [NW-1:0]          n;
    logic [NW-1:0]          fc_ext;
    logic [NW-1:0]          ld_idx;
    logic                   accept;
    logic                   mem_we;
    logic                   rd_ok;
    logic [MARGIN_W-1:0]    margin;
    logic [NW-1:0]          half_n;
    logic [NW-1:0]          cur_up;
    logic [NW-1:0]          scan_start;
    logic [NW-1:0]          nk_start;
    logic [NW-1:0]          loc_sel;

    assign fc_ext  = NW'(frame_count_reg);
    assign n       = (fc_ext > MAX_N) ? MAX_N : fc_ext;
    assign ld_idx  = NW'(entry_index);
    assign accept  = start && (state_reg == S_IDLE);
    assign mem_we  = accept && (action == ACT_LOAD) && (ld_idx < MAX_N);
    assign rd_ok   = (p_reg < n) && rd_word_reg.valid;
    assign margin  = MARGIN_W'(interval_reg) << MARGIN_SHIFT;
    assign half_n  = n >> 1;
    assign cur_up  = cur_reg + step_reg;
    assign scan_start = (cur_reg < NW'(SCAN_BACK)) ? '0 : cur_reg - NW'(SCAN_BACK);
    assign loc_sel = loc_found_reg ? loc_frame_reg : '0;
    assign nk_start = (loc_sel < NW'(NK_BACK)) ? '0 : loc_sel - NW'(NK_BACK);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ld_idx[IW-1:0]] <= '{valid: entry_valid, key: entry_key, pts: entry_time};
        end
        rd_word_reg <= mem[p_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            first_time_reg  <= '0;
            interval_reg    <= FRAME_INTERVAL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_COUNT:    frame_count_reg <= cfg_data[FCOUNT_W-1:0];
                REG_FIRST_TIME:     first_time_reg  <= cfg_data[TIME_W-1:0];
                REG_FRAME_INTERVAL: interval_reg    <= cfg_data[IVL_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            found_reg       <= 1'b0;
            frame_index_reg <= '0;
            found_time_reg  <= '0;
            act_reg         <= ACT_LOAD;
            ref_reg         <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            pts_reg         <= '0;
            last_reg        <= '0;
            p_reg           <= '0;
            cur_reg         <= '0;
            step_reg        <= '0;
            minf_reg        <= '0;
            cand_reg        <= '0;
            have_cand_reg   <= 1'b0;
            k_reg           <= '0;
            loc_found_reg   <= 1'b0;
            loc_frame_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && action != ACT_LOAD)
                    begin
                        act_reg   <= action;
                        ref_reg   <= query_time;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    lo_reg   <= (ref_reg < TIME_W'(margin)) ? '0 : ref_reg - TIME_W'(margin);
                    hi_reg   <= {1'b0, ref_reg} + (TIME_W + 1)'(margin);
                    minf_reg <= '0;
                    cur_reg  <= half_n;
                    step_reg <= (half_n + 1'b1) >> 1;
                    p_reg    <= half_n;
                    priority if (act_reg == ACT_PREV_KEY && ref_reg == '0)
                    begin
                        done_reg        <= 1'b1;
                        found_reg       <= 1'b0;
                        frame_index_reg <= '0;
                        found_time_reg  <= '0;
                        state_reg       <= S_IDLE;
                    end
                    else if (ref_reg <= first_time_reg)
                    begin
                        loc_found_reg <= 1'b1;
                        loc_frame_reg <= '0;
                        state_reg     <= S_LOC_DONE;
                    end
                    else
                    begin
                        state_reg <= S_BK_RD;
                    end
                end
                S_BK_RD:
                begin
                    state_reg <= S_BK_CHK;
                end
                S_BK_CHK:
                begin
                    priority if (rd_ok)
                    begin
                        pts_reg   <= rd_word_reg.pts;
                        cur_reg   <= p_reg;
                        state_reg <= S_PIVOT;
                    end
                    else if (p_reg <= minf_reg)
                    begin
                        p_reg     <= cur_reg + 1'b1;
                        state_reg <= S_FW_RD;
                    end
                    else
                    begin
                        p_reg     <= p_reg - 1'b1;
                        state_reg <= S_BK_RD;
                    end
                end
                S_FW_RD:
                begin
                    if (p_reg >= n)
                    begin
                        loc_found_reg <= 1'b0;
                        state_reg     <= S_LOC_DONE;
                    end
                    else
                    begin
                        minf_reg  <= p_reg;
                        state_reg <= S_FW_CHK;
                    end
                end
                S_FW_CHK:
                begin
                    if (rd_ok)
                    begin
                        pts_reg   <= rd_word_reg.pts;
                        cur_reg   <= p_reg;
                        state_reg <= S_PIVOT;
                    end
                    else
                    begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= S_FW_RD;
                    end
                end
                S_PIVOT:
                begin
                    priority if (pts_reg == ref_reg)
                    begin
                        loc_found_reg <= 1'b1;
                        loc_frame_reg <= cur_reg;
                        state_reg     <= S_LOC_DONE;
                    end
                    else if ((pts_reg >= lo_reg && {1'b0, pts_reg} <= hi_reg)
                             || step_reg < NW'(MIN_STEP))
                    begin
                        p_reg         <= scan_start;
                        k_reg         <= '0;
                        have_cand_reg <= 1'b0;
                        state_reg     <= S_SCAN_RD;
                    end
                    else
                    begin
                        // move the pivot by the current step, kept inside the live window
                        if (pts_reg > ref_reg)
                        begin
                            if (cur_reg <= step_reg + minf_reg)
                            begin
                                cur_reg <= minf_reg;
                                p_reg   <= minf_reg;
                            end
                            else
                            begin
                                cur_reg <= cur_reg - step_reg;
                                p_reg   <= cur_reg - step_reg;
                            end
                        end
                        else
                        begin
                            cur_reg <= (cur_up >= n) ? n - 1'b1 : cur_up;
                            p_reg   <= (cur_up >= n) ? n - 1'b1 : cur_up;
                        end
                        step_reg  <= (step_reg + 1'b1) >> 1;
                        state_reg <= S_BK_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    if (p_reg >= n || k_reg == SCAN_CNT_W'(SCAN_LEN))
                    begin
                        loc_found_reg <= have_cand_reg;
                        loc_frame_reg <= cand_reg;
                        state_reg     <= S_LOC_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK:
                begin
                    if (rd_ok && rd_word_reg.pts == ref_reg)
                    begin
                        loc_found_reg <= 1'b1;
                        loc_frame_reg <= p_reg;
                        state_reg     <= S_LOC_DONE;
                    end
                    else
                    begin
                        if (rd_ok && rd_word_reg.pts >= lo_reg && rd_word_reg.pts < ref_reg
                            && (!have_cand_reg || rd_word_reg.pts > last_reg))
                        begin
                            cand_reg      <= p_reg;
                            last_reg      <= rd_word_reg.pts;
                            have_cand_reg <= 1'b1;
                        end
                        p_reg     <= p_reg + 1'b1;
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_LOC_DONE:
                begin
                    unique case (act_reg)
                        ACT_NEXT_KEY:
                        begin
                            p_reg     <= nk_start;
                            state_reg <= S_NK_RD;
                        end
                        ACT_PREV_KEY:
                        begin
                            if (loc_found_reg)
                            begin
                                p_reg     <= loc_frame_reg;
                                state_reg <= S_PK_RD;
                            end
                            else
                            begin
                                done_reg        <= 1'b1;
                                found_reg       <= 1'b0;
                                frame_index_reg <= '0;
                                found_time_reg  <= '0;
                                state_reg       <= S_IDLE;
                            end
                        end
                        default:
                        begin
                            done_reg        <= 1'b1;
                            found_reg       <= loc_found_reg;
                            frame_index_reg <= EIDX_W'(loc_sel);
                            found_time_reg  <= '0;
                            state_reg       <= S_IDLE;
                        end
                    endcase
                end
                S_NK_RD:
                begin
                    if (p_reg >= n)
                    begin
                        done_reg        <= 1'b1;
                        found_reg       <= 1'b0;
                        frame_index_reg <= '0;
                        found_time_reg  <= '0;
                        state_reg       <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_NK_CHK;
                    end
                end
                S_NK_CHK:
                begin
                    if (rd_ok && rd_word_reg.key && rd_word_reg.pts > ref_reg)
                    begin
                        done_reg        <= 1'b1;
                        found_reg       <= 1'b1;
                        frame_index_reg <= EIDX_W'(p_reg);
                        found_time_reg  <= rd_word_reg.pts;
                        state_reg       <= S_IDLE;
                    end
                    else
                    begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= S_NK_RD;
                    end
                end
                S_PK_RD:
                begin
                    state_reg <= S_PK_CHK;
                end
                S_PK_CHK:
                begin
                    priority if (rd_ok && rd_word_reg.key && rd_word_reg.pts < ref_reg)
                    begin
                        done_reg        <= 1'b1;
                        found_reg       <= 1'b1;
                        frame_index_reg <= EIDX_W'(p_reg);
                        found_time_reg  <= rd_word_reg.pts;
                        state_reg       <= S_IDLE;
                    end
                    else if (p_reg == '0)
                    begin
                        done_reg        <= 1'b1;
                        found_reg       <= 1'b0;
                        frame_index_reg <= '0;
                        found_time_reg  <= '0;
                        state_reg       <= S_IDLE;
                    end
                    else
                    begin
                        p_reg     <= p_reg - 1'b1;
                        state_reg <= S_PK_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign frame_index = frame_index_reg;
    assign found_time  = found_time_reg;

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a query is still running");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (frame_index == '0 && found_time == '0))
        else $error("failed search carries nonzero payload");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_LOAD) |=> (!busy && !done))
        else $error("load transaction started a search or produced a result");

    a_at_before_time: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_AT_BEFORE) |=> (busy && !done))
        else $error("query transaction not taken into the search");
`endif

endmodule

// ===== verif/keyframe_seek_index_test.sv =====
module keyframe_seek_index_test;
    import ksi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_FRAMES = 4096;
    // frames loaded up front; frame counts stay at or below this so every read entry exists
    localparam int N_LOADED = 128;
    localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct {
        logic                found;
        logic [EIDX_W-1:0]   frame;
        logic [TIME_W-1:0]   ftime;
    } seek_res_t;

    typedef struct {
        logic [ACT_W-1:0]    act;
        logic [EIDX_W-1:0]   eidx;
        logic [TIME_W-1:0]   etime;
        logic                ev;
        logic                ek;
        logic [TIME_W-1:0]   qt;
        seek_res_t           res;
    } seek_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [ACT_W-1:0]    action;
    logic [EIDX_W-1:0]   entry_index;
    logic [TIME_W-1:0]   entry_time;
    logic                entry_valid;
    logic                entry_key;
    logic [TIME_W-1:0]   query_time;
    logic                done;
    logic                found;
    logic [EIDX_W-1:0]   frame_index;
    logic [TIME_W-1:0]   found_time;
    logic                cfg_write;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    keyframe_seek_index dut (.*);

    // shadow of the frame table and registers
    logic [63:0]  shadow_time [N_FRAMES];
    bit           shadow_valid [N_FRAMES];
    bit           shadow_key [N_FRAMES];
    int unsigned  cur_count;
    logic [63:0]  cur_first;
    int unsigned  cur_interval;

    seek_res_t    pending_seeks[$];
    int           mismatches;
    int           queries_seen;
    int           loads_sent;
    longint       cycles;

    function automatic int unsigned live_frames();
        return cur_count > N_FRAMES ? N_FRAMES : cur_count;
    endfunction

    function automatic bit frame_time(int unsigned i, output logic [63:0] t);
        t = 0;
        if (i >= live_frames() || !shadow_valid[i])
            return 0;
        t = shadow_time[i];
        return 1;
    endfunction

    function automatic bit frame_is_key(int unsigned i);
        return i < live_frames() && shadow_key[i];
    endfunction

    // bisection toward the reference time, then a 65-frame scan around the pivot
    function automatic bit find_at_or_before(logic [63:0] ref_t, output int unsigned frame);
        int unsigned n, cur, step, minf, t, k, cand;
        logic [63:0] margin, lo, hi, pts, last;
        bit have, have_cand;
        n = live_frames();
        frame = 0;
        minf = 0;
        cand = 0;
        last = 0;
        pts = 0;
        have_cand = 0;
        if (ref_t <= cur_first)
            return 1;
        margin = 64'(cur_interval) * 16;
        lo = ref_t < margin ? 64'd0 : ref_t - margin;
        hi = ref_t + margin;
        cur = n >> 1;
        step = (cur + 1) >> 1;
        forever
        begin
            t = cur;
            have = 0;
            forever
            begin
                if (frame_time(t, pts))
                begin
                    have = 1;
                    break;
                end
                if (t <= minf)
                    break;
                t--;
            end
            if (!have)
            begin
                t = cur + 1;
                forever
                begin
                    if (t >= n)
                        return 0;
                    minf = t;
                    if (frame_time(t, pts))
                        break;
                    t++;
                end
            end
            cur = t;
            if (pts == ref_t)
            begin
                frame = cur;
                return 1;
            end
            if (pts >= lo && pts <= hi)
                break;
            if (step < MIN_STEP)
                break;
            if (pts > ref_t)
            begin
                if (cur <= step + minf)
                    cur = minf;
                else
                    cur -= step;
            end
            else
            begin
                cur += step;
                if (cur >= n)
                    cur = n - 1;
            end
            step = (step + 1) >> 1;
        end
        cur = cur < SCAN_BACK ? 0 : cur - SCAN_BACK;
        for (k = 0; k < SCAN_LEN; k++)
        begin
            if (cur >= n)
                break;
            if (frame_time(cur, pts))
            begin
                if (pts == ref_t)
                begin
                    frame = cur;
                    return 1;
                end
                if (pts >= lo && (!have_cand || pts > last) && pts < ref_t)
                begin
                    cand = cur;
                    last = pts;
                    have_cand = 1;
                end
            end
            cur++;
        end
        frame = cand;
        return have_cand;
    endfunction

    function automatic seek_res_t predict_seek(logic [ACT_W-1:0] act, logic [TIME_W-1:0] qt);
        seek_res_t r;
        int unsigned frame, i, n, st;
        logic [63:0] ref_t, pts;
        bit ok;
        r = '{found: 0, frame: 0, ftime: 0};
        ref_t = {1'b0, qt};
        n = live_frames();
        frame = 0;
        if (act == ACT_AT_BEFORE)
        begin
            ok = find_at_or_before(ref_t, frame);
            r.found = ok;
            r.frame = ok ? EIDX_W'(frame) : '0;
        end
        else if (act == ACT_NEXT_KEY)
        begin
            if (!find_at_or_before(ref_t, st))
                st = 0;
            st = st < NK_BACK ? 0 : st - NK_BACK;
            for (i = st; i < n; i++)
            begin
                if (frame_is_key(i) && frame_time(i, pts) && pts > ref_t)
                begin
                    r = '{found: 1, frame: EIDX_W'(i), ftime: TIME_W'(pts)};
                    break;
                end
            end
        end
        else if (ref_t != 0 && find_at_or_before(ref_t, st))
        begin
            i = st + 1;
            while (i > 0)
            begin
                i--;
                if (frame_is_key(i) && frame_time(i, pts) && pts < ref_t)
                begin
                    r = '{found: 1, frame: EIDX_W'(i), ftime: TIME_W'(pts)};
                    break;
                end
            end
        end
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_seeks.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // results are stable at the falling edge
    always @(negedge clk)
    begin
        seek_res_t e;
        if (rst_n && done)
        begin
            queries_seen++;
            if (pending_seeks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0b frame=%0d time=%0d",
                             found, frame_index, found_time);
            end
            else
            begin
                e = pending_seeks.pop_front();
                if (found !== e.found || frame_index !== e.frame || found_time !== e.ftime)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp found=%0b frame=%0d time=%0d, got %0b %0d %0d",
                                 e.found, e.frame, e.ftime, found, frame_index, found_time);
                end
            end
        end
    end

    task automatic send(seek_row_t row, bit typed, int gap);
        bit acc;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        action <= row.act;
        entry_index <= row.eidx;
        entry_time <= row.etime;
        entry_valid <= row.ev;
        entry_key <= row.ek;
        query_time <= row.qt;
        do
        begin
            @(negedge clk);
            acc = !busy;
            @(posedge clk);
        end
        while (!acc);
        if (row.act == ACT_LOAD)
        begin
            shadow_time[row.eidx] = {1'b0, row.etime};
            shadow_valid[row.eidx] = row.ev;
            shadow_key[row.eidx] = row.ek;
            loads_sent++;
        end
        else
            pending_seeks.push_back(typed ? row.res : predict_seek(row.act, row.qt));
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_seeks.size() != 0 || busy);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_FRAME_COUNT)
            cur_count = 32'(val[FCOUNT_W-1:0]);
        else if (idx == REG_FIRST_TIME)
            cur_first = {1'b0, val};
        else if (idx == REG_FRAME_INTERVAL)
            cur_interval = 32'(val[IVL_W-1:0]);
    endtask

    function automatic seek_row_t load_row(int unsigned idx, logic [TIME_W-1:0] t,
                                          bit v, bit k);
        seek_row_t r;
        r = '{act: ACT_LOAD, eidx: EIDX_W'(idx), etime: t, ev: v, ek: k,
              qt: TIME_W'($urandom), res: '{found: 0, frame: 0, ftime: 0}};
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    function automatic seek_row_t query_row(logic [ACT_W-1:0] act, logic [TIME_W-1:0] qt);
        seek_row_t r;
        r = '{act: act, eidx: EIDX_W'($urandom), etime: rand_time(), ev: 1'($urandom),
              ek: 1'($urandom), qt: qt, res: '{found: 0, frame: 0, ftime: 0}};
        return r;
    endfunction

    // steady timeline: times rise by one interval with some jitter, a few frames lack time
    task automatic load_timeline(int unsigned lo, int unsigned cnt, logic [TIME_W-1:0] base,
                                 int unsigned ivl, bit noisy, bit burst);
        int unsigned i;
        logic [TIME_W-1:0] t;
        for (i = lo; i < lo + cnt && i < N_FRAMES; i++)
        begin
            t = base + TIME_W'(i) * TIME_W'(ivl)
                + TIME_W'(ivl > 4 ? $urandom_range(0, ivl / 4) : 0);
            if (noisy && $urandom_range(0, 7) == 0)
                t = rand_time();
            send(load_row(i, t, $urandom_range(0, 7) != 0, $urandom_range(0, 9) == 0),
                 0, burst ? 0 : int'($urandom_range(0, 11)));
        end
    endtask

    seek_row_t reset_rows[4];
    seek_row_t edge_rows[$];

    initial
    begin
        int unsigned ph, j, cnt, ivl, span, pick;
        logic [TIME_W-1:0] base, qt;
        bit nogap;
        rst_n = 0;
        start = 0;
        action = ACT_LOAD;
        entry_index = 0;
        entry_time = 0;
        entry_valid = 0;
        entry_key = 0;
        query_time = 0;
        cfg_write = 0;
        cfg_index = REG_FRAME_COUNT;
        cfg_data = 0;
        cycles = 0;
        mismatches = 0;
        queries_seen = 0;
        loads_sent = 0;
        cur_count = 0;
        cur_first = 0;
        cur_interval = 32'(FRAME_INTERVAL_RESET);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the low part of the table once so that no query ever reads an empty slot
        load_timeline(0, N_LOADED, 63'd1000, 32'(FRAME_INTERVAL_RESET), 0, 1);

        // with no frames counted: only a time at or before the first frame succeeds
        reset_rows[0] = query_row(ACT_AT_BEFORE, 63'd5);
        reset_rows[1] = query_row(ACT_AT_BEFORE, 63'd0);
        reset_rows[1].res = '{found: 1, frame: 0, ftime: 0};
        reset_rows[2] = query_row(ACT_NEXT_KEY, TIME_MAX);
        reset_rows[3] = query_row(ACT_PREV_KEY, 63'd0);
        foreach (reset_rows[r])
            send(reset_rows[r], 1, $urandom_range(0, 11));
        drain();

        write_reg(REG_FRAME_COUNT, 63'd64);
        write_reg(REG_FIRST_TIME, 63'd41000);
        write_reg(REG_UNUSED, {CFG_W{1'b1}});
        edge_rows.push_back(load_row(4095, TIME_MAX, 1, 1));
        edge_rows.push_back(load_row(10, 63'd0, 0, 0));
        edge_rows.push_back(load_row(12, 63'd481000, 1, 1));
        edge_rows.push_back(load_row(40, 63'd1601000, 1, 1));
        edge_rows.push_back(query_row(ACT_AT_BEFORE, 63'd0));
        edge_rows.push_back(query_row(ACT_AT_BEFORE, 63'd41000));
        edge_rows.push_back(query_row(ACT_AT_BEFORE, 63'd481000));
        edge_rows.push_back(query_row(ACT_AT_BEFORE, 63'd500000));
        edge_rows.push_back(query_row(ACT_AT_BEFORE, TIME_MAX));
        edge_rows.push_back(query_row(ACT_NEXT_KEY, 63'd0));
        edge_rows.push_back(query_row(ACT_NEXT_KEY, 63'd481000));
        edge_rows.push_back(query_row(ACT_NEXT_KEY, TIME_MAX));
        edge_rows.push_back(query_row(ACT_PREV_KEY, 63'd0));
        edge_rows.push_back(query_row(ACT_PREV_KEY, 63'd1601001));
        edge_rows.push_back(query_row(ACT_PREV_KEY, TIME_MAX));
        foreach (edge_rows[r])
            send(edge_rows[r], 0, $urandom_range(0, 11));
        drain();

        for (ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: cnt = N_LOADED;
                1: cnt = 0;
                2: cnt = 1;
                3: cnt = N_LOADED - 1;
                default: cnt = $urandom_range(0, 3) == 0 ? $urandom_range(64, N_LOADED)
                                                         : $urandom_range(2, 63);
            endcase
            case (ph % 4)
                0: ivl = $urandom_range(1000, 100000);
                1: ivl = 0;
                2: ivl = 24'hFFFFFF;
                default: ivl = $urandom_range(1, 5000);
            endcase
            base = ph == 3 ? TIME_MAX - TIME_W'(N_FRAMES) * TIME_W'(ivl) - TIME_W'(ivl)
                           : TIME_W'($urandom_range(0, 1 << 20));
            nogap = ph % 3 == 0;
            write_reg(REG_FRAME_COUNT, CFG_W'({$urandom, $urandom}) & ~63'h1FFF | 63'(cnt));
            write_reg(REG_FIRST_TIME, ph == 5 ? TIME_MAX : base);
            write_reg(REG_FRAME_INTERVAL,
                      CFG_W'({$urandom, $urandom}) & ~63'hFFFFFF | 63'(ivl));
            span = cnt > 0 ? cnt : 1;
            load_timeline(span > 10 ? $urandom_range(0, span - 10) : 0, 10, base, ivl,
                          ph >= 6, nogap);
            for (j = 0; j < 20; j++)
            begin
                pick = $urandom_range(0, span - 1);
                case ($urandom_range(0, 5))
                    0: qt = rand_time();
                    1: qt = shadow_time[pick][TIME_W-1:0];
                    default: qt = base + TIME_W'(pick) * TIME_W'(ivl)
                                  + TIME_W'($urandom_range(0, 2 * ivl + 3))
                                  - TIME_W'($urandom_range(0, ivl + 1));
                endcase
                send(query_row(ACT_W'($urandom_range(ACT_AT_BEFORE, ACT_PREV_KEY)), qt), 0,
                     nogap ? 0 : int'($urandom_range(0, 11)));
            end
            drain();
        end

        repeat (200) @(posedge clk);
        $display("%0d loads and %0d query results over frame counts from 0 to %0d",
                 loads_sent, queries_seen, N_LOADED);
        $display("frame intervals 0 to 16777215, %0d mismatches", mismatches);
        if (mismatches == 0 && pending_seeks.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
